// File: src/dsf_pkg.sv
// Shared types and constants for the duplicating sample FIFO.
`default_nettype none
package dsf_pkg;

  // Configuration register word indexes.
  localparam logic [1:0] REG_THRESHOLD     = 2'd0;
  localparam logic [1:0] REG_MULTIPLIER    = 2'd1;
  localparam logic [1:0] REG_RESET_SAMPLES = 2'd2;

  localparam logic [15:0] THRESHOLD_RST     = 16'd16384;
  localparam logic [4:0]  MULTIPLIER_RST    = 5'd2;
  localparam logic [15:0] RESET_SAMPLES_RST = 16'd1000;
  localparam logic [4:0]  MULT_MAX          = 5'd16;
  localparam logic [15:0] FRAMES_LEFT_RST   = 16'd1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PUSH,
    ST_READ,
    ST_POP
  } dsf_state_t;

  // Sequencer commands to each channel.
  typedef struct packed {
    logic load;   // capture the incoming sample and its copy count
    logic push;   // one push iteration
    logic rd;     // read the head entry
    logic pop;    // retire the head entry
    logic clear;  // empty the FIFO
  } dsf_ctrl_t;

endpackage
`default_nettype wire

// File: src/duplicating_sample_fifo.sv
// Flow: idle takes a frame, push writes its copies, read fetches the head entry and pop
// loads the output register; only then is the next frame taken. Copies written: 1, or up
// to the multiplier (at most 16) if the sample is over the threshold, fewer if cut short
// by the countdown. A held result blocks the head read; copies go one per cycle per store.
// Synchronous active-low reset empties both FIFOs, sets the countdown to one and
// loads the register defaults; the sample stores themselves are not cleared.
`default_nettype none
module duplicating_sample_fifo
  import dsf_pkg::*;
#(
  parameter int FIFO_DEPTH  = 65536,
  parameter int CHANNELS    = 2,
  parameter int SAMPLE_BITS = 16,
  localparam int DW = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_tvalid,
  output logic               in_tready,
  input  wire logic [DW-1:0] in_tdata,    // left_sample, right_sample
  output logic               out_tvalid,
  input  wire logic          out_tready,
  output logic      [DW-1:0] out_tdata,   // left_out, right_out
  input  wire logic          cfg_psel,
  input  wire logic          cfg_penable,
  input  wire logic          cfg_pwrite,
  input  wire logic [3:0]    cfg_paddr,
  input  wire logic [31:0]   cfg_pwdata,
  output logic      [31:0]   cfg_prdata,
  output logic               cfg_pready
);

  dsf_state_t       state_r, state_nxt;
  dsf_ctrl_t        ctrl;
  logic [15:0]      frames_left_r, frames_left_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [DW-1:0]    out_data_r;
  logic             out_load;
  logic [15:0]      threshold;
  logic [4:0]       multiplier;
  logic [4:0]       mult_eff;
  logic [15:0]      reset_samples;
  logic             l_busy, r_busy;
  logic [SAMPLE_BITS-1:0] l_pop, r_pop;

  dsf_cfg u_cfg (
    .clk           (clk),
    .rst_n         (rst_n),
    .psel          (cfg_psel),
    .penable       (cfg_penable),
    .pwrite        (cfg_pwrite),
    .paddr         (cfg_paddr),
    .pwdata        (cfg_pwdata),
    .prdata        (cfg_prdata),
    .pready        (cfg_pready),
    .threshold     (threshold),
    .multiplier    (multiplier),
    .reset_samples (reset_samples)
  );

  always_comb begin
    if (multiplier == 5'd0) begin
      mult_eff = 5'd1;
    end else if (multiplier > MULT_MAX) begin
      mult_eff = MULT_MAX;
    end else begin
      mult_eff = multiplier;
    end
  end

  dsf_chan #(
    .FIFO_DEPTH  (FIFO_DEPTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_left (
    .clk         (clk),
    .rst_n       (rst_n),
    .ctrl        (ctrl),
    .sample      (in_tdata[SAMPLE_BITS-1:0]),
    .threshold   (threshold),
    .mult        (mult_eff),
    .frames_left (frames_left_r),
    .busy        (l_busy),
    .pop_data    (l_pop)
  );

  if (CHANNELS > 1) begin : g_right
    dsf_chan #(
      .FIFO_DEPTH  (FIFO_DEPTH),
      .SAMPLE_BITS (SAMPLE_BITS)
    ) u_right (
      .clk         (clk),
      .rst_n       (rst_n),
      .ctrl        (ctrl),
      .sample      (in_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]),
      .threshold   (threshold),
      .mult        (mult_eff),
      .frames_left (frames_left_r),
      .busy        (r_busy),
      .pop_data    (r_pop)
    );
  end else begin : g_mono
    assign r_busy = 1'b0;
    assign r_pop  = '0;
  end

  always_comb begin
    state_nxt       = state_r;
    frames_left_nxt = frames_left_r;
    ctrl            = '0;
    out_load        = 1'b0;
    in_tready       = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          ctrl.load = 1'b1;
          state_nxt = ST_PUSH;
        end
      end
      ST_PUSH: begin
        ctrl.push = 1'b1;
        if (!l_busy && !r_busy) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        // Hold the head read until the output register can take the result.
        if (!out_valid_r || out_tready) begin
          ctrl.rd         = 1'b1;
          frames_left_nxt = frames_left_r - 16'd1;
          state_nxt       = ST_POP;
        end
      end
      ST_POP: begin
        ctrl.pop = 1'b1;
        out_load = 1'b1;
        if (frames_left_r == 16'd0) begin
          ctrl.clear      = 1'b1;
          frames_left_nxt = (reset_samples == 16'd0) ? 16'd1 : reset_samples;
        end
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      frames_left_r <= FRAMES_LEFT_RST;
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      frames_left_r <= frames_left_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data_r <= DW'({r_pop, l_pop});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
`default_nettype wire

// File: src/dsf_ram.sv
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none
module dsf_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 65536,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire logic [WIDTH-1:0] wr_data,
  input  wire logic             rd_en,
  input  wire logic [AW-1:0]    rd_addr,
  output logic      [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: src/dsf_cfg.sv
// APB configuration registers: threshold, multiplier and countdown reload.
`default_nettype none
module dsf_cfg
  import dsf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready,
  output logic      [15:0] threshold,
  output logic      [4:0]  multiplier,
  output logic      [15:0] reset_samples
);

  logic [15:0] threshold_r;
  logic [4:0]  multiplier_r;
  logic [15:0] reset_samples_r;
  logic        wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      threshold_r     <= THRESHOLD_RST;
      multiplier_r    <= MULTIPLIER_RST;
      reset_samples_r <= RESET_SAMPLES_RST;
    end else if (wr_en) begin
      case (paddr[3:2])
        REG_THRESHOLD:     threshold_r     <= pwdata[15:0];
        REG_MULTIPLIER:    multiplier_r    <= pwdata[4:0];
        REG_RESET_SAMPLES: reset_samples_r <= pwdata[15:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_THRESHOLD:     prdata = 32'(threshold_r);
      REG_MULTIPLIER:    prdata = 32'(multiplier_r);
      REG_RESET_SAMPLES: prdata = 32'(reset_samples_r);
      default:           prdata = 32'd0;
    endcase
  end

  assign threshold     = threshold_r;
  assign multiplier    = multiplier_r;
  assign reset_samples = reset_samples_r;

endmodule
`default_nettype wire

// File: src/dsf_chan.sv
// One channel: FIFO pointers, fill count, copy counter and the sample store.
`default_nettype none
module dsf_chan
  import dsf_pkg::*;
#(
  parameter int FIFO_DEPTH  = 65536,
  parameter int SAMPLE_BITS = 16
) (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire dsf_ctrl_t              ctrl,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire logic [15:0]            threshold,
  input  wire logic [4:0]             mult,
  input  wire logic [15:0]            frames_left,
  output logic                        busy,
  output logic      [SAMPLE_BITS-1:0] pop_data
);

  localparam int AW   = $clog2(FIFO_DEPTH);
  localparam int FW   = $clog2(FIFO_DEPTH + 1);
  localparam int CMPW = (FW > 16) ? FW : 16;
  localparam int CW   = (SAMPLE_BITS > 16) ? SAMPLE_BITS : 16;

  logic [SAMPLE_BITS-1:0] sample_r;
  logic [4:0]             rem_r, rem_nxt;
  logic [FW-1:0]          fill_r, fill_nxt;
  logic [AW-1:0]          head_r, head_nxt;
  logic [AW-1:0]          tail_r, tail_nxt;
  logic [SAMPLE_BITS-1:0] rd_data;
  logic signed [SAMPLE_BITS-1:0] smp_s;
  logic signed [15:0]     thr_s;
  logic signed [CW-1:0]   smp_ext, thr_ext;
  logic                   over;
  logic                   full;
  logic                   wr_en;

  assign smp_s   = sample;
  assign thr_s   = threshold;
  assign smp_ext = CW'(smp_s);
  assign thr_ext = CW'(thr_s);

  // Stop pushing once the fill has passed the countdown.
  assign over = CMPW'(fill_r) > CMPW'(frames_left);
  assign full = fill_r == FW'(FIFO_DEPTH);
  assign wr_en = ctrl.push && (rem_r != 5'd0) && !over && !full;
  assign busy = rem_r != 5'd0;

  always_comb begin
    rem_nxt  = rem_r;
    fill_nxt = fill_r;
    head_nxt = head_r;
    tail_nxt = tail_r;
    if (ctrl.load) begin
      rem_nxt = (smp_ext > thr_ext) ? mult : 5'd1;
    end
    if (ctrl.push && (rem_r != 5'd0)) begin
      if (over) begin
        rem_nxt = 5'd0;
      end else begin
        rem_nxt = rem_r - 5'd1;
        if (!full) begin
          fill_nxt = fill_r + 1'b1;
          tail_nxt = (tail_r == AW'(FIFO_DEPTH - 1)) ? '0 : tail_r + 1'b1;
        end
      end
    end
    if (ctrl.pop && (fill_r != '0)) begin
      fill_nxt = fill_r - 1'b1;
      head_nxt = (head_r == AW'(FIFO_DEPTH - 1)) ? '0 : head_r + 1'b1;
    end
    if (ctrl.clear) begin
      fill_nxt = '0;
      head_nxt = '0;
      tail_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rem_r  <= 5'd0;
      fill_r <= '0;
      head_r <= '0;
      tail_r <= '0;
    end else begin
      rem_r  <= rem_nxt;
      fill_r <= fill_nxt;
      head_r <= head_nxt;
      tail_r <= tail_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      sample_r <= sample;
    end
  end

  dsf_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (FIFO_DEPTH)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (tail_r),
    .wr_data (sample_r),
    .rd_en   (ctrl.rd),
    .rd_addr (head_r),
    .rd_data (rd_data)
  );

  assign pop_data = (fill_r != '0) ? rd_data : '0;

endmodule
`default_nettype wire
